/* hw/rtl/hmm_viterbi_decoder_defines.svh */
// Assertion macros used by the HMM Viterbi decoder top level.
`ifndef HMM_VITERBI_DECODER_DEFINES_SVH
`define HMM_VITERBI_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define HMMVD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hmmvd same-cycle check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define HMMVD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hmmvd next-cycle check failed");

`endif

/* hw/rtl/hmmvd_pkg.sv */
// Shared types and constants of the HMM Viterbi decoder.
package hmmvd_pkg;

	localparam int OPC_W = 2;
	localparam int ST_W = 2;
	localparam int VAL_W = 16;
	localparam int IDX_W = 10;
	localparam int NS_W = 3;
	// Sum of a score, a transition and a sample; and a difference of two sums.
	localparam int SUM_W = 18;
	localparam int DIFF_W = 19;

	localparam logic [NS_W-1:0] NUM_STATES_RST = 3'd4;
	localparam logic signed [DIFF_W-1:0] SAT_MIN = -19'sd32768;

	typedef enum logic [OPC_W-1:0] {
		OP_LOAD_TRANS = 2'd0,
		OP_LOAD_INIT  = 2'd1,
		OP_SAMPLE     = 2'd2,
		OP_READ       = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ_OUT,
		ST_COL_RD,
		ST_COL_ACC,
		ST_COL_RAW,
		ST_COL_WR,
		ST_BT_RD,
		ST_BT_ACC,
		ST_BT_STORE
	} state_t;

	typedef struct packed {
		logic en;
		logic first;
	} acs_ctrl_t;

endpackage

/* hw/rtl/hmmvd_if.sv */
// Valid/ready channel interfaces for input and result words.
interface hmmvd_in_if;
	import hmmvd_pkg::*;
	logic valid;
	logic ready;
	logic [OPC_W-1:0] opcode;
	logic [ST_W-1:0] from_state;
	logic [ST_W-1:0] to_state;
	logic signed [VAL_W-1:0] log_value;
	logic last_step;
	logic [IDX_W-1:0] step_index;

	modport source (output valid, opcode, from_state, to_state, log_value, last_step,
		step_index, input ready);
	modport sink (input valid, opcode, from_state, to_state, log_value, last_step,
		step_index, output ready);
endinterface

interface hmmvd_out_if;
	import hmmvd_pkg::*;
	logic valid;
	logic ready;
	logic [ST_W-1:0] decoded_state;
	logic path_ready;

	modport source (output valid, decoded_state, path_ready, input ready);
	modport sink (input valid, decoded_state, path_ready, output ready);
endinterface

/* hw/rtl/hmmvd_acs.sv */
// Shared add-compare-select unit: keeps the running maximum and its index.
module hmmvd_acs #(
	parameter int W = 18,
	parameter int IW = 2
) (
	input logic clk,
	input hmmvd_pkg::acs_ctrl_t ctrl,
	input logic signed [W-1:0] cand,
	input logic [IW-1:0] idx,
	output logic signed [W-1:0] best,
	output logic [IW-1:0] arg
);
	logic signed [W-1:0] best_q;
	logic [IW-1:0] arg_q;

	// A strict compare keeps the lowest index on ties.
	always_ff @(posedge clk) begin
		if (ctrl.en && (ctrl.first || cand > best_q)) begin
			best_q <= cand;
			arg_q <= idx;
		end
	end

	assign best = best_q;
	assign arg = arg_q;
endmodule

/* hw/rtl/hmm_viterbi_decoder.sv */
// HMM Viterbi decoder top level: loads, score recursion, backtrace and path reads.
// Loads are accepted only in idle. A read registers the path word; the read-out state
// then loads it into the output register, stalling while a held result is not taken.
// Step-completing samples' recursion over K states is bound by the single score port.
// Reset clears control state only; the stores hold garbage until written.
`include "hmm_viterbi_decoder_defines.svh"
module hmm_viterbi_decoder #(
	parameter int MAX_STATES = 4,
	parameter int MAX_STEPS = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [hmmvd_pkg::NS_W-1:0] cfg_wr_data,
	hmmvd_in_if.sink in_ch,
	hmmvd_out_if.source out_ch
);
	import hmmvd_pkg::*;

	localparam int SW = $clog2(MAX_STATES);
	localparam int KW = $clog2(MAX_STATES + 1);
	localparam int TW = $clog2(MAX_STEPS);
	localparam int CW = $clog2(MAX_STEPS + 1);
	localparam int DEPTH = MAX_STEPS * MAX_STATES;
	localparam int AW = $clog2(DEPTH);

	state_t state_q, state_d;
	logic [NS_W-1:0] num_states_q;
	logic [KW-1:0] k_eff, k_use_q;
	logic [SW-1:0] last_idx, j_end, k_q, j_q, nxt_q, col_sel, acs_arg;
	logic [CW-1:0] step_count_q, path_len_q;
	logic [TW-1:0] bt_t_q, t_cur;
	logic last_q, first_col_q, t_zero, have_room;
	logic accept, to_ok, from_ok, completes, out_load;
	logic out_valid_q, out_path_ready_q, rd_hit_q;
	logic [ST_W-1:0] out_state_q;

	logic signed [VAL_W-1:0] trans_q [MAX_STATES][MAX_STATES];
	logic signed [VAL_W-1:0] init_q [MAX_STATES];
	logic signed [VAL_W-1:0] samp_q [MAX_STATES];
	logic signed [SUM_W-1:0] raw_q [MAX_STATES];
	logic signed [SUM_W-1:0] top_q, raw_new, cand, acs_best;
	logic signed [VAL_W-1:0] trans_sel, sc_wdata, sc_rdata;
	logic signed [DIFF_W-1:0] diff;
	logic signed [VAL_W-1:0] sc_mem [DEPTH];
	logic [SW-1:0] path_mem [MAX_STEPS];
	logic [SW-1:0] path_rdata;
	logic [AW-1:0] sc_addr;
	logic sc_re, sc_we;
	acs_ctrl_t acs_ctrl;

	// Effective number of states: clamped into 2..MAX_STATES.
	always_comb begin
		if (num_states_q < 2) begin
			k_eff = KW'(2);
		end else if (int'(num_states_q) > MAX_STATES) begin
			k_eff = KW'(MAX_STATES);
		end else begin
			k_eff = KW'(num_states_q);
		end
	end

	assign last_idx = SW'(k_use_q - KW'(1));
	assign accept = in_ch.valid && in_ch.ready;
	assign to_ok = int'(in_ch.to_state) < MAX_STATES;
	assign from_ok = int'(in_ch.from_state) < MAX_STATES;
	assign completes = to_ok && (int'(in_ch.to_state) == int'(k_eff) - 1);
	assign have_room = int'(step_count_q) < MAX_STEPS;
	assign t_cur = TW'(step_count_q);
	assign t_zero = (step_count_q == '0);
	assign j_end = t_zero ? '0 : last_idx;
	assign out_load = (state_q == ST_READ_OUT) && (!out_valid_q || out_ch.ready);

	// Score memory address and port control.
	always_comb begin
		case (state_q)
			ST_COL_RD: begin
				sc_addr = t_zero ? '0 :
					AW'(TW'(t_cur - TW'(1))) * AW'(MAX_STATES) + AW'(j_q);
			end
			ST_COL_WR: sc_addr = AW'(t_cur) * AW'(MAX_STATES) + AW'(k_q);
			default: sc_addr = AW'(bt_t_q) * AW'(MAX_STATES) + AW'(j_q);
		endcase
	end
	assign sc_re = (state_q == ST_COL_RD) || (state_q == ST_BT_RD);
	assign sc_we = (state_q == ST_COL_WR);

	// Normalize against the column maximum and saturate at the bottom.
	assign diff = DIFF_W'(raw_q[k_q]) - DIFF_W'(top_q);
	assign sc_wdata = (diff < SAT_MIN) ? 16'sh8000 : diff[VAL_W-1:0];

	// Candidate for the shared compare unit.
	assign col_sel = (state_q == ST_BT_ACC) ? nxt_q : k_q;
	assign trans_sel = trans_q[j_q][col_sel];
	always_comb begin
		if (state_q == ST_BT_ACC) begin
			cand = SUM_W'(sc_rdata) + (first_col_q ? SUM_W'(0) : SUM_W'(trans_sel));
		end else if (t_zero) begin
			cand = SUM_W'(init_q[k_q]);
		end else begin
			cand = SUM_W'(sc_rdata) + SUM_W'(trans_sel);
		end
	end
	assign acs_ctrl.en = (state_q == ST_COL_ACC) || (state_q == ST_BT_ACC);
	assign acs_ctrl.first = (j_q == '0);
	assign raw_new = acs_best + SUM_W'(samp_q[k_q]);

	hmmvd_acs #(
		.W(SUM_W),
		.IW(SW)
	) u_acs (
		.clk(clk),
		.ctrl(acs_ctrl),
		.cand(cand),
		.idx(j_q),
		.best(acs_best),
		.arg(acs_arg)
	);

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_ch.opcode == OP_SAMPLE && completes) begin
						if (have_room) begin
							state_d = ST_COL_RD;
						end else if (in_ch.last_step) begin
							state_d = ST_BT_RD;
						end
					end else if (in_ch.opcode == OP_READ) begin
						state_d = ST_READ_OUT;
					end
				end
			end
			ST_READ_OUT: if (out_load) state_d = ST_IDLE;
			ST_COL_RD: state_d = ST_COL_ACC;
			ST_COL_ACC: state_d = (j_q == j_end) ? ST_COL_RAW : ST_COL_RD;
			ST_COL_RAW: state_d = (k_q == last_idx) ? ST_COL_WR : ST_COL_RD;
			ST_COL_WR: begin
				if (k_q == last_idx) begin
					state_d = last_q ? ST_BT_RD : ST_IDLE;
				end
			end
			ST_BT_RD: state_d = ST_BT_ACC;
			ST_BT_ACC: state_d = (j_q == last_idx) ? ST_BT_STORE : ST_BT_RD;
			ST_BT_STORE: state_d = (bt_t_q == '0) ? ST_IDLE : ST_BT_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.decoded_state = out_state_q;
	assign out_ch.path_ready = out_path_ready_q;

	// Control registers and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_states_q <= NUM_STATES_RST;
			step_count_q <= '0;
			path_len_q <= '0;
			out_valid_q <= 1'b0;
			k_use_q <= KW'(2);
			k_q <= '0;
			j_q <= '0;
			nxt_q <= '0;
			bt_t_q <= '0;
			last_q <= 1'b0;
			first_col_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				num_states_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_use_q <= k_eff;
						last_q <= in_ch.last_step;
						k_q <= '0;
						j_q <= '0;
						first_col_q <= 1'b1;
						bt_t_q <= TW'(step_count_q - CW'(1));
					end
				end
				ST_COL_ACC: if (j_q != j_end) j_q <= j_q + SW'(1);
				ST_COL_RAW: begin
					j_q <= '0;
					k_q <= (k_q == last_idx) ? '0 : k_q + SW'(1);
				end
				ST_COL_WR: begin
					if (k_q == last_idx) begin
						step_count_q <= step_count_q + CW'(1);
						bt_t_q <= t_cur;
						k_q <= '0;
						j_q <= '0;
					end else begin
						k_q <= k_q + SW'(1);
					end
				end
				ST_BT_ACC: if (j_q != last_idx) j_q <= j_q + SW'(1);
				ST_BT_STORE: begin
					nxt_q <= acs_arg;
					j_q <= '0;
					first_col_q <= 1'b0;
					if (bt_t_q == '0) begin
						path_len_q <= step_count_q;
						step_count_q <= '0;
					end else begin
						bt_t_q <= bt_t_q - TW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Parameter stores and per-step working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			case (in_ch.opcode)
				OP_LOAD_TRANS: begin
					if (from_ok && to_ok) begin
						trans_q[SW'(in_ch.from_state)][SW'(in_ch.to_state)] <= in_ch.log_value;
					end
				end
				OP_LOAD_INIT: if (to_ok) init_q[SW'(in_ch.to_state)] <= in_ch.log_value;
				OP_SAMPLE: if (to_ok) samp_q[SW'(in_ch.to_state)] <= in_ch.log_value;
				default: begin
				end
			endcase
		end
		if (state_q == ST_COL_RAW) begin
			raw_q[k_q] <= raw_new;
			if (k_q == '0 || raw_new > top_q) begin
				top_q <= raw_new;
			end
		end
		if (out_load) begin
			out_state_q <= rd_hit_q ? ST_W'(path_rdata) : '0;
			out_path_ready_q <= rd_hit_q;
		end
	end

	// Score column memory: one port, registered read.
	always_ff @(posedge clk) begin
		if (sc_we) begin
			sc_mem[sc_addr] <= sc_wdata;
		end
		if (sc_re) begin
			sc_rdata <= sc_mem[sc_addr];
		end
	end

	// Decoded path memory: written by the backtrace, read by read words.
	always_ff @(posedge clk) begin
		if (state_q == ST_BT_STORE) begin
			path_mem[bt_t_q] <= acs_arg;
		end
		if (accept && in_ch.opcode == OP_READ) begin
			path_rdata <= path_mem[TW'(in_ch.step_index)];
			rd_hit_q <= (int'(in_ch.step_index) < int'(path_len_q)) &&
				(int'(in_ch.step_index) < MAX_STEPS);
		end
	end

	`HMMVD_ASSERT_NEXT(a_out_load, out_load, out_valid_q)
	`HMMVD_ASSERT_SAME(a_step_bound, 1'b1, int'(step_count_q) <= MAX_STEPS)
	`HMMVD_ASSERT_SAME(a_ready_path, out_valid_q && out_path_ready_q, path_len_q != '0)
	`HMMVD_ASSERT_NEXT(a_bt_done, state_q == ST_BT_STORE && bt_t_q == '0, step_count_q == '0 && state_q == ST_IDLE)
endmodule
